@@ rtl/core/bldc_speed_governor_unit_assert.svh @@
// ----------------------------------------------------------------------------
// BLDC speed governor assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BLDC_SPEED_GOVERNOR_UNIT_ASSERT_SVH
`define BLDC_SPEED_GOVERNOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BSG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bsg assertion failed");
`define BSG_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bsg assertion failed");
`else
`define BSG_ASSERT(label, clk, rst, prop)
`define BSG_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ rtl/core/bsg_pkg.sv @@
// ----------------------------------------------------------------------------
// BLDC speed governor package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package bsg_pkg;

   localparam int PERIOD_BITS    = 16;
   localparam int COUNT_BITS     = 8;
   localparam int CSR_DATA_BITS  = (PERIOD_BITS > COUNT_BITS) ? PERIOD_BITS : COUNT_BITS;
   localparam int CSR_INDEX_BITS = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALT_PERIOD   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_PERIOD  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUALIFY_COUNT = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FINE_LIMIT    = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COARSE_POWER  = CSR_INDEX_BITS'(4);

   localparam logic [PERIOD_BITS-1:0] HALT_PERIOD_RESET  = PERIOD_BITS'(11000);
   localparam logic [PERIOD_BITS-1:0] START_PERIOD_RESET = PERIOD_BITS'(12000);
   localparam logic [COUNT_BITS-1:0]  QUALIFY_RESET      = COUNT_BITS'(20);
   localparam logic [PERIOD_BITS-1:0] FINE_LIMIT_RESET   = PERIOD_BITS'(200);
   localparam logic [PERIOD_BITS-1:0] COARSE_POWER_RESET = PERIOD_BITS'(1000);

   // Status of a bit-serial arithmetic unit.
   typedef struct packed {
      logic busy;
      logic done;
   } bsg_unit_status_type;

endpackage

@@ rtl/core/bsg_divider.sv @@
// ----------------------------------------------------------------------------
// BLDC speed governor divider
// Restoring divider, one quotient bit per cycle. Divides (dividend_hi << N)
// by divisor, where dividend_hi is below divisor, giving an N-bit quotient.
// ----------------------------------------------------------------------------
`include "bldc_speed_governor_unit_assert.svh"

module bsg_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [bsg_pkg::PERIOD_BITS-1:0]      dividend_hi,
   input  logic [bsg_pkg::PERIOD_BITS-1:0]      divisor,
   output logic [bsg_pkg::PERIOD_BITS-1:0]      quotient,
   output bsg_pkg::bsg_unit_status_type         status
);
   import bsg_pkg::*;

   localparam int CNT_BITS = $clog2(PERIOD_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(PERIOD_BITS - 1);

   logic [PERIOD_BITS-1:0] rem_ff, rem_in;
   logic [PERIOD_BITS-1:0] quo_ff, quo_in;
   logic [PERIOD_BITS-1:0] dsr_ff, dsr_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [PERIOD_BITS:0]   shifted;
   logic [PERIOD_BITS:0]   diff;
   logic                   take;

   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign take    = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend_hi;
         dsr_in  = divisor;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so the difference fits N bits.
         rem_in = take ? diff[PERIOD_BITS-1:0] : shifted[PERIOD_BITS-1:0];
         quo_in = {quo_ff[PERIOD_BITS-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `BSG_ASSERT(a_rem_below_divisor, clock, reset, busy_ff |-> rem_ff < dsr_ff)
   `BSG_ASSERT(a_start_sets_busy, clock, reset, start |=> busy_ff)
   `BSG_ASSERT(a_done_not_busy, clock, reset, done_ff |-> !busy_ff)

endmodule

@@ rtl/core/bsg_multiplier.sv @@
// ----------------------------------------------------------------------------
// BLDC speed governor multiplier
// Shift-add multiplier, one multiplier bit per cycle, of an N-bit
// multiplicand by an (N+1)-bit multiplier.
// ----------------------------------------------------------------------------
module bsg_multiplier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [bsg_pkg::PERIOD_BITS-1:0]      multiplicand,
   input  logic [bsg_pkg::PERIOD_BITS:0]        multiplier,
   output logic [2*bsg_pkg::PERIOD_BITS:0]      product,
   output bsg_pkg::bsg_unit_status_type         status
);
   import bsg_pkg::*;

   localparam int CNT_BITS = $clog2(PERIOD_BITS + 1);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(PERIOD_BITS);

   logic [PERIOD_BITS-1:0] hi_ff, hi_in;
   logic [PERIOD_BITS:0]   lo_ff, lo_in;
   logic [PERIOD_BITS-1:0] mcand_ff, mcand_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [PERIOD_BITS:0]   sum;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         hi_in    = '0;
         lo_in    = multiplier;
         mcand_in = multiplicand;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // The partial product moves right as multiplier bits are consumed.
         hi_in  = sum[PERIOD_BITS:1];
         lo_in  = {sum[0], lo_ff[PERIOD_BITS:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign product     = {hi_ff, lo_ff};
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ rtl/core/bldc_speed_governor_unit.sv @@
// ----------------------------------------------------------------------------
// BLDC speed governor
// Per-commutation halted/running mode control with startup qualification
// counters and a proportional drive computed by serial divide and multiply.
// ----------------------------------------------------------------------------
//   Channel  Direction  Ports                                   Word
//   req      in         req_period_ticks, req_target_period     one per step
//   rsp      out        rsp_drive_power, rsp_running            one per req word
//   csr      in         csr_write_en, csr_index, csr_wdata      one register
//
// A word that needs the proportional formula passes from acceptance through the
// bit-serial divider and the shift-add multiplier before its result is registered;
// any other word goes through the pending drive register to the output register.
// One word is in work at a time; the next is taken once the result is in the
// output register, which holds it while rsp_ready is low.
// Synchronous reset restores state, settings, counters, mode and rsp_valid only.
// ----------------------------------------------------------------------------
`include "bldc_speed_governor_unit_assert.svh"

module bldc_speed_governor_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bsg_pkg::PERIOD_BITS-1:0]       req_period_ticks,
   input  logic [bsg_pkg::PERIOD_BITS-1:0]       req_target_period,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bsg_pkg::PERIOD_BITS-1:0]       rsp_drive_power,
   output logic                                  rsp_running,
   input  logic                                  csr_write_en,
   input  logic [bsg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bsg_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import bsg_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_DELIVER
   } state_type;

   function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
      count_up = (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
   endfunction

   state_type              state_ff, state_in;
   logic [PERIOD_BITS-1:0] halt_ff, halt_in;
   logic [PERIOD_BITS-1:0] start_ff, start_in;
   logic [COUNT_BITS-1:0]  qual_ff, qual_in;
   logic [PERIOD_BITS-1:0] fine_ff, fine_in;
   logic [PERIOD_BITS-1:0] coarse_ff, coarse_in;
   logic                   run_mode_ff, run_mode_in;
   logic [COUNT_BITS-1:0]  dq_ff, dq_in;
   logic [COUNT_BITS-1:0]  rq_ff, rq_in;
   logic [PERIOD_BITS-1:0] pend_drive_ff, pend_drive_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_BITS-1:0] rsp_drive_ff, rsp_drive_in;
   logic                   rsp_running_ff, rsp_running_in;

   logic                   req_fire;
   logic                   dq_band, rq_band;
   logic [COUNT_BITS-1:0]  dq_new, rq_base, rq_new;
   logic                   div_start, mul_start;
   logic [PERIOD_BITS-1:0] quotient;
   logic [PERIOD_BITS:0]   slack;
   logic [2*PERIOD_BITS:0] product;
   logic [PERIOD_BITS-1:0] formula_drive;
   bsg_unit_status_type    div_status, mul_status;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign dq_band = (req_period_ticks < start_ff) && (req_period_ticks > (start_ff >> 3));
   assign rq_band = (req_period_ticks < halt_ff) && (req_period_ticks > (halt_ff >> 3));
   assign dq_new  = dq_band ? count_up(dq_ff) : '0;
   // Leaving the drive band also clears the run counter before the run band check.
   assign rq_base = dq_band ? rq_ff : '0;
   assign rq_new  = rq_band ? count_up(rq_base) : '0;

   assign div_start = req_fire && run_mode_ff && (req_period_ticks <= halt_ff)
                      && (req_period_ticks > req_target_period)
                      && (req_period_ticks > fine_ff);
   assign mul_start = (state_ff == ST_DIVIDE) && div_status.done;
   assign slack     = {1'b1, {PERIOD_BITS{1'b0}}} - {1'b0, quotient};

   // The drive is the product shifted down by N-1, saturated to N bits.
   assign formula_drive = (|product[2*PERIOD_BITS:2*PERIOD_BITS-1]) ? '1
                          : product[2*PERIOD_BITS-2:PERIOD_BITS-1];

   bsg_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend_hi (req_target_period),
      .divisor     (req_period_ticks),
      .quotient    (quotient),
      .status      (div_status)
   );

   bsg_multiplier u_multiplier (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (period_ff),
      .multiplier   (slack),
      .product      (product),
      .status       (mul_status)
   );

   always_comb begin
      state_in       = state_ff;
      halt_in        = halt_ff;
      start_in       = start_ff;
      qual_in        = qual_ff;
      fine_in        = fine_ff;
      coarse_in      = coarse_ff;
      run_mode_in    = run_mode_ff;
      dq_in          = dq_ff;
      rq_in          = rq_ff;
      pend_drive_in  = pend_drive_ff;
      period_in      = period_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_running_in = rsp_running_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_HALT_PERIOD:   halt_in   = csr_wdata[PERIOD_BITS-1:0];
            CSR_START_PERIOD:  start_in  = csr_wdata[PERIOD_BITS-1:0];
            CSR_QUALIFY_COUNT: qual_in   = csr_wdata[COUNT_BITS-1:0];
            CSR_FINE_LIMIT:    fine_in   = csr_wdata[PERIOD_BITS-1:0];
            CSR_COARSE_POWER:  coarse_in = csr_wdata[PERIOD_BITS-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               period_in     = req_period_ticks;
               pend_drive_in = '0;
               state_in      = ST_DELIVER;
               if (run_mode_ff) begin
                  if (req_period_ticks > halt_ff) begin
                     dq_in       = '0;
                     rq_in       = '0;
                     run_mode_in = 1'b0;
                  end else if (req_period_ticks > req_target_period) begin
                     if (req_period_ticks > fine_ff) begin
                        state_in = ST_DIVIDE;
                     end else begin
                        pend_drive_in = coarse_ff;
                     end
                  end
               end else begin
                  dq_in = dq_new;
                  rq_in = rq_new;
                  if (dq_new > qual_ff) begin
                     pend_drive_in = {2'b00, req_period_ticks[PERIOD_BITS-1:2]};
                  end
                  if (rq_new > qual_ff) begin
                     run_mode_in = 1'b1;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            if (mul_status.done) begin
               pend_drive_in = formula_drive;
               state_in      = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_drive_in   = pend_drive_ff;
               rsp_running_in = run_mode_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         halt_ff      <= HALT_PERIOD_RESET;
         start_ff     <= START_PERIOD_RESET;
         qual_ff      <= QUALIFY_RESET;
         fine_ff      <= FINE_LIMIT_RESET;
         coarse_ff    <= COARSE_POWER_RESET;
         run_mode_ff  <= 1'b0;
         dq_ff        <= '0;
         rq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halt_ff      <= halt_in;
         start_ff     <= start_in;
         qual_ff      <= qual_in;
         fine_ff      <= fine_in;
         coarse_ff    <= coarse_in;
         run_mode_ff  <= run_mode_in;
         dq_ff        <= dq_in;
         rq_ff        <= rq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_drive_ff  <= pend_drive_in;
      period_ff      <= period_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_running_ff <= rsp_running_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_power = rsp_drive_ff;
   assign rsp_running     = rsp_running_ff;

   `BSG_ASSERT(a_accept_blocks, clock, reset, req_valid && req_ready |=> !req_ready)
   `BSG_ASSERT(a_div_done_in_divide, clock, reset, div_status.done |-> state_ff == ST_DIVIDE)
   `BSG_ASSERT(a_mul_done_in_multiply, clock, reset, mul_status.done |-> state_ff == ST_MULTIPLY)
   `BSG_ASSERT(a_mode_matches, clock, reset, rsp_valid_ff && state_ff == ST_IDLE |-> rsp_running_ff == run_mode_ff)
   `BSG_ASSERT_NORST(a_reset_idle, clock, reset |=> !rsp_valid_ff && state_ff == ST_IDLE)

endmodule

@@ verif/bldc_speed_governor_unit_tb.sv @@
// ----------------------------------------------------------------------------
// BLDC speed governor testbench
// Drives commutation words through the request channel with bursty timing,
// stalls the response channel, and checks every result against the table for
// checked directed rows, else against a local model of the mode machine, the
// qualification counters and the drive formula. A short directed table covers
// band edges, mode changes, saturation of the formula and register masking.
// Random phases with changing register settings follow.
// ----------------------------------------------------------------------------
module bldc_speed_governor_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsg_pkg::*;

   typedef logic [PERIOD_BITS-1:0]    period_type;
   typedef logic [COUNT_BITS-1:0]     count_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   typedef struct packed {
      period_type drive;
      logic       running;
   } gov_result_type;

   typedef enum logic [0:0] {ROW_WORD, ROW_CSR} row_kind_type;

   // a is the period or the register value, b the target period.
   typedef struct packed {
      row_kind_type  kind;
      csr_index_type index;
      period_type    a;
      period_type    b;
      logic          checked;
      period_type    exp_drive;
      logic          exp_running;
   } dir_row_type;

   localparam int        PERIOD_MAX = (1 << PERIOD_BITS) - 1;
   localparam count_type COUNT_MAX  = '1;

   localparam csr_index_type CSR_UNMAPPED_LOW  = csr_index_type'(5);
   localparam csr_index_type CSR_UNMAPPED_HIGH = '1;

   localparam int N_DIRECTED = 31;
   localparam dir_row_type DIRECTED [0:N_DIRECTED-1] = '{
      // Defaults after reset; the lower band edge is exclusive.
      '{ROW_WORD, '0, 16'd0,     16'd0,     1'b1, 16'd0,     1'b0},
      '{ROW_WORD, '0, 16'd65535, 16'd65535, 1'b1, 16'd0,     1'b0},
      '{ROW_WORD, '0, 16'd1500,  16'd0,     1'b1, 16'd0,     1'b0},
      // Only the low byte of the qualify register is kept, so this writes zero.
      '{ROW_CSR,  CSR_QUALIFY_COUNT, 16'h0100, 16'd0, 1'b0, 16'd0, 1'b0},
      '{ROW_WORD, '0, 16'd5000,  16'd0,     1'b1, 16'd1250,  1'b1},
      // Stall while running clears both counters and the run mode.
      '{ROW_WORD, '0, 16'd11001, 16'd0,     1'b1, 16'd0,     1'b0},
      // Startup drive without running: period inside the start band only.
      '{ROW_WORD, '0, 16'd11999, 16'd0,     1'b1, 16'd2999,  1'b0},
      '{ROW_WORD, '0, 16'd11000, 16'd0,     1'b1, 16'd2750,  1'b0},
      '{ROW_WORD, '0, 16'd10999, 16'd0,     1'b1, 16'd2749,  1'b1},
      '{ROW_WORD, '0, 16'd100,   16'd100,   1'b1, 16'd0,     1'b1},
      '{ROW_WORD, '0, 16'd200,   16'd199,   1'b1, 16'd1000,  1'b1},
      '{ROW_WORD, '0, 16'd201,   16'd0,     1'b1, 16'd402,   1'b1},
      '{ROW_WORD, '0, 16'd10000, 16'd9999,  1'b0, 16'd0,     1'b0},
      '{ROW_WORD, '0, 16'd11000, 16'd65535, 1'b1, 16'd0,     1'b1},
      '{ROW_CSR,  CSR_HALT_PERIOD, 16'hFFFF, 16'd0, 1'b0, 16'd0, 1'b0},
      // Formula overflow saturates at full scale.
      '{ROW_WORD, '0, 16'd65535, 16'd0,     1'b1, 16'd65535, 1'b1},
      '{ROW_WORD, '0, 16'd65535, 16'd65534, 1'b0, 16'd0,     1'b0},
      '{ROW_WORD, '0, 16'd40000, 16'd12345, 1'b0, 16'd0,     1'b0},
      '{ROW_CSR,  CSR_FINE_LIMIT, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{ROW_WORD, '0, 16'd1,     16'd0,     1'b1, 16'd2,     1'b1},
      '{ROW_CSR,  CSR_COARSE_POWER, 16'hFFFF, 16'd0, 1'b0, 16'd0, 1'b0},
      '{ROW_CSR,  CSR_FINE_LIMIT, 16'hFFFF, 16'd0, 1'b0, 16'd0, 1'b0},
      '{ROW_WORD, '0, 16'd65535, 16'd1,     1'b1, 16'd65535, 1'b1},
      '{ROW_CSR,  CSR_HALT_PERIOD, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{ROW_WORD, '0, 16'd0,     16'd0,     1'b1, 16'd0,     1'b1},
      '{ROW_WORD, '0, 16'd1,     16'd0,     1'b1, 16'd0,     1'b0},
      '{ROW_WORD, '0, 16'd0,     16'd0,     1'b1, 16'd0,     1'b0},
      // Writes to unmapped indexes must leave every register alone.
      '{ROW_CSR,  CSR_UNMAPPED_HIGH, 16'h5555, 16'd0, 1'b0, 16'd0, 1'b0},
      '{ROW_CSR,  CSR_UNMAPPED_LOW,  16'hAAAA, 16'd0, 1'b0, 16'd0, 1'b0},
      '{ROW_CSR,  CSR_START_PERIOD, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0},
      '{ROW_WORD, '0, 16'd0,     16'd0,     1'b1, 16'd0,     1'b0}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   period_type    req_period_ticks = '0;
   period_type    req_target_period = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   period_type    rsp_drive_power;
   logic          rsp_running;
   logic          csr_write_en = 1'b0;
   csr_index_type csr_index = '0;
   csr_data_type  csr_wdata = '0;

   bldc_speed_governor_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_period_ticks  (req_period_ticks),
      .req_target_period (req_target_period),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive_power   (rsp_drive_power),
      .rsp_running       (rsp_running),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // Governor model: register copies and state as they are after reset.
   period_type halt_lim   = HALT_PERIOD_RESET;
   period_type start_lim  = START_PERIOD_RESET;
   count_type  qual_lim   = QUALIFY_RESET;
   period_type fine_lim   = FINE_LIMIT_RESET;
   period_type coarse_drv = COARSE_POWER_RESET;
   logic       gov_running = 1'b0;
   count_type  drive_qual_cnt = '0;
   count_type  run_qual_cnt = '0;

   gov_result_type pending_drive_q[$];
   int unsigned err_cnt = 0;
   int unsigned burst_left = 8;
   int unsigned stall_left = 0;
   int unsigned calm_left = 0;

   function automatic count_type count_bump(count_type c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic period_in_band(period_type p, period_type upper);
      return (p < upper) && (p > (upper >> 3));
   endfunction

   function automatic gov_result_type govern_step(period_type p, period_type t);
      logic [63:0] ratio;
      logic [63:0] slack;
      logic [63:0] prod;
      gov_result_type res;
      res.drive = '0;
      if (gov_running) begin
         if (p > halt_lim) begin
            drive_qual_cnt = '0;
            run_qual_cnt = '0;
            gov_running = 1'b0;
         end else if (p > t) begin
            if (p > fine_lim) begin
               ratio = (64'(t) << PERIOD_BITS) / 64'(p);
               slack = (64'd1 << PERIOD_BITS) - ratio;
               prod = (64'(p) * slack) >> (PERIOD_BITS - 1);
               res.drive = (prod > 64'(PERIOD_MAX)) ? '1 : prod[PERIOD_BITS-1:0];
            end else begin
               res.drive = coarse_drv;
            end
         end
      end else begin
         // Leaving the start band clears both counters before the run band is seen.
         if (period_in_band(p, start_lim)) begin
            drive_qual_cnt = count_bump(drive_qual_cnt);
         end else begin
            drive_qual_cnt = '0;
            run_qual_cnt = '0;
         end
         if (drive_qual_cnt > qual_lim) res.drive = p >> 2;
         if (period_in_band(p, halt_lim)) run_qual_cnt = count_bump(run_qual_cnt);
         else run_qual_cnt = '0;
         if (run_qual_cnt > qual_lim) gov_running = 1'b1;
      end
      res.running = gov_running;
      return res;
   endfunction

   function automatic void apply_csr(csr_index_type idx, csr_data_type val);
      case (idx)
         CSR_HALT_PERIOD:   halt_lim = val[PERIOD_BITS-1:0];
         CSR_START_PERIOD:  start_lim = val[PERIOD_BITS-1:0];
         CSR_QUALIFY_COUNT: qual_lim = val[COUNT_BITS-1:0];
         CSR_FINE_LIMIT:    fine_lim = val[PERIOD_BITS-1:0];
         CSR_COARSE_POWER:  coarse_drv = val[PERIOD_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic period_type pick_period(int lo, int hi);
      if (lo > hi) return period_type'($urandom);
      return period_type'($urandom_range(hi, lo));
   endfunction

   // Called at a rising edge. Valid stays high on return unless the burst ended,
   // so a following word can reuse the same edge.
   task automatic send_word(period_type p, period_type t, logic has_exp,
                            gov_result_type exp_res);
      gov_result_type res;
      int unsigned gap;
      req_valid <= 1'b1;
      req_period_ticks <= p;
      req_target_period <= t;
      do @(posedge clock); while (!req_ready);
      res = govern_step(p, t);
      pending_drive_q.push_back(has_exp ? exp_res : res);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_drive_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, csr_data_type val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_csr(idx, val);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: mostly ready, with stall runs and long stretches of no stall.
   always @(posedge clock) begin
      if (calm_left != 0) begin
         calm_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         case ($urandom_range(0, 19))
            0: calm_left = $urandom_range(50, 400);
            1, 2, 3, 4, 5, 6: stall_left = $urandom_range(1, 15);
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      gov_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drive_q.size() == 0) begin
            err_cnt++;
            $display("%0t: unexpected word: actual drive %0d running %0b",
                     $time, rsp_drive_power, rsp_running);
         end else begin
            want = pending_drive_q.pop_front();
            if (rsp_drive_power !== want.drive || rsp_running !== want.running) begin
               err_cnt++;
               $display("%0t: mismatch: expected drive %0d running %0b, actual drive %0d running %0b",
                        $time, want.drive, want.running, rsp_drive_power, rsp_running);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("bldc_speed_governor_unit_tb: errors");
      $finish;
   end

   initial begin
      dir_row_type    row;
      gov_result_type row_exp;
      period_type     p;
      period_type     t;
      csr_data_type   v_halt;
      csr_data_type   v_start;
      csr_data_type   v_qual;
      csr_data_type   v_fine;
      csr_data_type   v_coarse;
      int             noise_pct;
      int             solo_pct;
      int             n_words;
      int             r;
      int             s_lo;
      int             s_hi;
      int             h_lo;
      int             h_hi;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CSR) begin
            settle();
            write_csr(row.index, row.a);
         end else begin
            row_exp.drive = row.exp_drive;
            row_exp.running = row.exp_running;
            send_word(row.a, row.b, row.checked, row_exp);
         end
      end

      for (int phase = 0; phase < 9; phase++) begin
         settle();
         noise_pct = 8;
         solo_pct = 15;
         n_words = 120;
         v_halt = HALT_PERIOD_RESET;
         v_start = START_PERIOD_RESET;
         v_qual = csr_data_type'(QUALIFY_RESET);
         v_fine = FINE_LIMIT_RESET;
         v_coarse = COARSE_POWER_RESET;
         case (phase)
            0, 1: begin
               // Long clean in-band runs push both counters into saturation.
               v_qual = (phase == 0) ? csr_data_type'(COUNT_MAX)
                                     : csr_data_type'(COUNT_MAX) - 1'b1;
               noise_pct = 0;
               solo_pct = 0;
               n_words = 300;
            end
            2: begin
               v_halt = '1;
               v_start = '1;
               v_qual = '0;
               v_fine = '0;
               v_coarse = '1;
               n_words = 100;
            end
            3: begin
               v_halt = csr_data_type'(40000);
               v_start = csr_data_type'(8000);
               v_qual = csr_data_type'(3);
               v_fine = '1;
               v_coarse = '0;
               n_words = 100;
            end
            4: ;
            default: begin
               v_halt = csr_data_type'($urandom_range(300, 40000));
               v_start = csr_data_type'($urandom_range(300, 50000));
               v_qual = csr_data_type'($urandom_range(0, 24));
               v_fine = csr_data_type'($urandom_range(0, 3000));
               v_coarse = csr_data_type'($urandom);
            end
         endcase
         write_csr(CSR_HALT_PERIOD, v_halt);
         write_csr(CSR_START_PERIOD, v_start);
         write_csr(CSR_QUALIFY_COUNT, v_qual);
         write_csr(CSR_FINE_LIMIT, v_fine);
         write_csr(CSR_COARSE_POWER, v_coarse);
         if ($urandom_range(0, 1) == 0)
            write_csr(csr_index_type'($urandom_range(CSR_UNMAPPED_HIGH, CSR_UNMAPPED_LOW)),
                      csr_data_type'($urandom));

         repeat (n_words) begin
            r = $urandom_range(0, 99);
            t = period_type'($urandom);
            if (r < noise_pct) begin
               p = period_type'($urandom);
            end else if (!gov_running) begin
               s_lo = int'(start_lim >> 3) + 1;
               s_hi = int'(start_lim) - 1;
               h_lo = int'(halt_lim >> 3) + 1;
               h_hi = int'(halt_lim) - 1;
               if (r < noise_pct + solo_pct)
                  p = pick_period(s_lo, s_hi);
               else
                  p = pick_period((s_lo > h_lo) ? s_lo : h_lo, (s_hi < h_hi) ? s_hi : h_hi);
            end else if (r < noise_pct + 8) begin
               p = pick_period(int'(halt_lim) + 1, PERIOD_MAX);
            end else begin
               t = pick_period(0, int'(halt_lim));
               case ($urandom_range(0, 9))
                  0, 1: p = pick_period(0, int'(t));
                  2: begin
                     p = pick_period(1, int'((fine_lim < halt_lim) ? fine_lim : halt_lim));
                     t = pick_period(0, int'(p) - 1);
                  end
                  default: p = pick_period(int'(t) + 1, int'(halt_lim));
               endcase
            end
            send_word(p, t, 1'b0, '0);
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (err_cnt == 0)
         $display("bldc_speed_governor_unit_tb: clean");
      else
         $display("bldc_speed_governor_unit_tb: errors");
      $finish;
   end

endmodule
